// File: hw/rtl/rvcx_pkg.sv
package rvcx_pkg;

   localparam int CINSN_W = 16;
   localparam int INSN_W  = 32;

   typedef logic [CINSN_W-1:0] cinsn_type;
   typedef logic [INSN_W-1:0]  insn_type;

   typedef struct packed {
      insn_type expanded;
      logic     legal;
   } rsp_type;

   // major opcodes of the 32-bit encoding
   localparam logic [6:0] OPC_LOAD      = 7'h03;
   localparam logic [6:0] OPC_LOAD_FP   = 7'h07;
   localparam logic [6:0] OPC_OP_IMM    = 7'h13;
   localparam logic [6:0] OPC_OP_IMM_32 = 7'h1b;
   localparam logic [6:0] OPC_STORE     = 7'h23;
   localparam logic [6:0] OPC_STORE_FP  = 7'h27;
   localparam logic [6:0] OPC_OP        = 7'h33;
   localparam logic [6:0] OPC_LUI       = 7'h37;
   localparam logic [6:0] OPC_OP_32     = 7'h3b;
   localparam logic [6:0] OPC_BRANCH    = 7'h63;
   localparam logic [6:0] OPC_JALR      = 7'h67;
   localparam logic [6:0] OPC_JAL       = 7'h6f;
   localparam logic [6:0] OPC_SYSTEM    = 7'h73;

   localparam logic [6:0]  F7_SUB     = 7'h20;
   localparam logic [6:0]  F7_BASE    = 7'h00;
   localparam logic [11:0] IMM_SRAI   = 12'h400;
   localparam logic [11:0] IMM_EBREAK = 12'h001;

   // compressed quadrants
   localparam logic [1:0] QUAD_0 = 2'b00;
   localparam logic [1:0] QUAD_1 = 2'b01;
   localparam logic [1:0] QUAD_2 = 2'b10;

   localparam logic [4:0] REG_ZERO = 5'd0;
   localparam logic [4:0] REG_RA   = 5'd1;
   localparam logic [4:0] REG_SP   = 5'd2;

endpackage

// File: hw/rtl/rvcx_channels.sv
interface rvcx_req_if;
   logic                       valid;
   logic                       ready;
   logic [rvcx_pkg::CINSN_W-1:0] cinsn;

   modport source (output valid, output cinsn, input ready);
   modport sink (input valid, input cinsn, output ready);
endinterface

interface rvcx_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [rvcx_pkg::INSN_W-1:0] expanded;
   logic                        legal;

   modport source (output valid, output expanded, output legal, input ready);
   modport sink (input valid, input expanded, input legal, output ready);
endinterface

// File: hw/rtl/rvc_instruction_expander_unit.sv
// path: input register, decode, result register, then rsp
// throughput: one request per cycle unless rsp stalls; set by the single decode
// stage between the input register and the result register
// reset: synchronous; clears both stage valid bits, payload registers are not reset
module rvc_instruction_expander_unit (
   input  logic       clock,
   input  logic       reset,
   rvcx_req_if.sink   req_ch,
   rvcx_rsp_if.source rsp_ch
);
   import rvcx_pkg::*;

   logic      in_valid_ff;
   logic      in_valid_in;
   cinsn_type cinsn_ff;
   cinsn_type cinsn_in;
   logic      out_valid_ff;
   logic      out_valid_in;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   rsp_type   dec_result;
   logic      out_free;
   logic      in_free;
   logic      req_take;

   rvcx_decode u_decode (
      .cinsn  (cinsn_ff),
      .result (dec_result)
   );

   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign in_free  = !in_valid_ff || out_free;
   assign req_take = req_ch.valid && in_free;

   assign req_ch.ready    = in_free;
   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.expanded = rsp_ff.expanded;
   assign rsp_ch.legal    = rsp_ff.legal;

   always_comb begin
      in_valid_in  = in_free ? req_ch.valid : in_valid_ff;
      cinsn_in     = req_take ? req_ch.cinsn : cinsn_ff;
      out_valid_in = out_free ? in_valid_ff : out_valid_ff;
      // result register loads only when a decoded request moves forward
      rsp_in       = (out_free && in_valid_ff) ? dec_result : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cinsn_ff <= cinsn_in;
      rsp_ff   <= rsp_in;
   end

endmodule

// File: hw/rtl/rvcx_decode.sv
module rvcx_decode (
   input  rvcx_pkg::cinsn_type cinsn,
   output rvcx_pkg::rsp_type   result
);
   import rvcx_pkg::*;

   function automatic insn_type fmt_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                      logic [4:0] rd, logic [6:0] op);
      return {imm, rs1, f3, rd, op};
   endfunction

   function automatic insn_type fmt_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                      logic [2:0] f3, logic [6:0] op);
      return {imm[11:5], rs2, rs1, f3, imm[4:0], op};
   endfunction

   function automatic insn_type fmt_b(logic [12:0] imm, logic [4:0] rs1, logic [2:0] f3);
      return {imm[12], imm[10:5], REG_ZERO, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
   endfunction

   function automatic insn_type fmt_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                      logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
      return {f7, rs2, rs1, f3, rd, op};
   endfunction

   function automatic insn_type fmt_j(logic [20:0] imm);
      return {imm[20], imm[10:1], imm[11], imm[19:12], REG_ZERO, OPC_JAL};
   endfunction

   logic [1:0]  quad;
   logic [2:0]  funct3;
   logic [4:0]  rd;
   logic [4:0]  rs2;
   logic [4:0]  reg_hi;
   logic [4:0]  reg_lo;
   logic [11:0] imm6;
   logic [11:0] shamt6;
   logic [11:0] uimm_w;
   logic [11:0] uimm_d;
   logic [11:0] uimm_dsp;
   logic [11:0] uimm_dss;
   logic [11:0] uimm_4spn;
   logic [11:0] uimm_lwsp;
   logic [11:0] uimm_swsp;
   logic [11:0] imm_16sp;
   logic [12:0] br_off;
   logic [20:0] jmp_off;
   logic [19:0] lui_imm;
   logic [1:0]  alu_op;
   logic [2:0]  alu_f3;
   logic [6:0]  alu_f7;

   assign quad   = cinsn[1:0];
   assign funct3 = cinsn[15:13];
   assign rd     = cinsn[11:7];
   assign rs2    = cinsn[6:2];
   assign reg_hi = {2'b01, cinsn[9:7]};
   assign reg_lo = {2'b01, cinsn[4:2]};
   assign alu_op = cinsn[6:5];

   assign imm6      = {{7{cinsn[12]}}, cinsn[6:2]};
   assign shamt6    = {6'd0, cinsn[12], cinsn[6:2]};
   assign uimm_w    = {5'd0, cinsn[5], cinsn[12:10], cinsn[6], 2'd0};
   assign uimm_d    = {4'd0, cinsn[6:5], cinsn[12:10], 3'd0};
   assign uimm_dsp  = {3'd0, cinsn[4:2], cinsn[12], cinsn[6:5], 3'd0};
   assign uimm_dss  = {3'd0, cinsn[9:7], cinsn[12:10], 3'd0};
   assign uimm_4spn = {2'd0, cinsn[10:7], cinsn[12:11], cinsn[5], cinsn[6], 2'd0};
   assign uimm_lwsp = {4'd0, cinsn[3:2], cinsn[12], cinsn[6:4], 2'd0};
   assign uimm_swsp = {4'd0, cinsn[8:7], cinsn[12:9], 2'd0};
   assign imm_16sp  = {{3{cinsn[12]}}, cinsn[4:3], cinsn[5], cinsn[2], cinsn[6], 4'd0};
   assign br_off    = {{5{cinsn[12]}}, cinsn[6:5], cinsn[2], cinsn[11:10], cinsn[4:3], 1'b0};
   assign jmp_off   = {{10{cinsn[12]}}, cinsn[8], cinsn[10:9], cinsn[6], cinsn[7], cinsn[2],
                       cinsn[11], cinsn[5:3], 1'b0};
   assign lui_imm   = {{15{cinsn[12]}}, cinsn[6:2]};

   // c.sub, c.xor, c.or, c.and and the word forms
   always_comb begin
      alu_f7 = (alu_op == 2'b00) ? F7_SUB : F7_BASE;
      case (alu_op)
         2'b00:   alu_f3 = 3'd0;
         2'b01:   alu_f3 = 3'd4;
         2'b10:   alu_f3 = 3'd6;
         default: alu_f3 = 3'd7;
      endcase
   end

   always_comb begin
      result.expanded = '0;
      result.legal    = 1'b0;
      case (quad)
         QUAD_0: begin
            case (funct3)
               3'd0: begin
                  if (uimm_4spn != 12'd0) begin
                     result.expanded = fmt_i(uimm_4spn, REG_SP, 3'd0, reg_lo, OPC_OP_IMM);
                     result.legal    = 1'b1;
                  end
               end
               3'd1: begin
                  result.expanded = fmt_i(uimm_d, reg_hi, 3'd3, reg_lo, OPC_LOAD_FP);
                  result.legal    = 1'b1;
               end
               3'd2: begin
                  result.expanded = fmt_i(uimm_w, reg_hi, 3'd2, reg_lo, OPC_LOAD);
                  result.legal    = 1'b1;
               end
               3'd3: begin
                  result.expanded = fmt_i(uimm_d, reg_hi, 3'd3, reg_lo, OPC_LOAD);
                  result.legal    = 1'b1;
               end
               3'd5: begin
                  result.expanded = fmt_s(uimm_d, reg_lo, reg_hi, 3'd3, OPC_STORE_FP);
                  result.legal    = 1'b1;
               end
               3'd6: begin
                  result.expanded = fmt_s(uimm_w, reg_lo, reg_hi, 3'd2, OPC_STORE);
                  result.legal    = 1'b1;
               end
               3'd7: begin
                  result.expanded = fmt_s(uimm_d, reg_lo, reg_hi, 3'd3, OPC_STORE);
                  result.legal    = 1'b1;
               end
               default: begin
                  result.legal = 1'b0;
               end
            endcase
         end
         QUAD_1: begin
            case (funct3)
               3'd0: begin
                  result.expanded = fmt_i(imm6, rd, 3'd0, rd, OPC_OP_IMM);
                  result.legal    = 1'b1;
               end
               3'd1: begin
                  if (rd != REG_ZERO) begin
                     result.expanded = fmt_i(imm6, rd, 3'd0, rd, OPC_OP_IMM_32);
                     result.legal    = 1'b1;
                  end
               end
               3'd2: begin
                  result.expanded = fmt_i(imm6, REG_ZERO, 3'd0, rd, OPC_OP_IMM);
                  result.legal    = 1'b1;
               end
               3'd3: begin
                  if (rd == REG_SP) begin
                     if (imm_16sp != 12'd0) begin
                        result.expanded = fmt_i(imm_16sp, REG_SP, 3'd0, REG_SP, OPC_OP_IMM);
                        result.legal    = 1'b1;
                     end
                  end else if (rd != REG_ZERO && imm6 != 12'd0) begin
                     result.expanded = {lui_imm, rd, OPC_LUI};
                     result.legal    = 1'b1;
                  end
               end
               3'd4: begin
                  case (cinsn[11:10])
                     2'b00: begin
                        result.expanded = fmt_i(shamt6, reg_hi, 3'd5, reg_hi, OPC_OP_IMM);
                        result.legal    = 1'b1;
                     end
                     2'b01: begin
                        result.expanded = fmt_i(IMM_SRAI | shamt6, reg_hi, 3'd5, reg_hi,
                                                OPC_OP_IMM);
                        result.legal    = 1'b1;
                     end
                     2'b10: begin
                        result.expanded = fmt_i(imm6, reg_hi, 3'd7, reg_hi, OPC_OP_IMM);
                        result.legal    = 1'b1;
                     end
                     default: begin
                        if (!cinsn[12]) begin
                           result.expanded = fmt_r(alu_f7, reg_lo, reg_hi, alu_f3, reg_hi,
                                                   OPC_OP);
                           result.legal    = 1'b1;
                        end else if (!alu_op[1]) begin
                           result.expanded = fmt_r(alu_f7, reg_lo, reg_hi, 3'd0, reg_hi,
                                                   OPC_OP_32);
                           result.legal    = 1'b1;
                        end
                     end
                  endcase
               end
               3'd5: begin
                  result.expanded = fmt_j(jmp_off);
                  result.legal    = 1'b1;
               end
               3'd6: begin
                  result.expanded = fmt_b(br_off, reg_hi, 3'd0);
                  result.legal    = 1'b1;
               end
               default: begin
                  result.expanded = fmt_b(br_off, reg_hi, 3'd1);
                  result.legal    = 1'b1;
               end
            endcase
         end
         QUAD_2: begin
            case (funct3)
               3'd0: begin
                  if (rd != REG_ZERO) begin
                     result.expanded = fmt_i(shamt6, rd, 3'd1, rd, OPC_OP_IMM);
                     result.legal    = 1'b1;
                  end
               end
               3'd1: begin
                  result.expanded = fmt_i(uimm_dsp, REG_SP, 3'd3, rd, OPC_LOAD_FP);
                  result.legal    = 1'b1;
               end
               3'd2: begin
                  if (rd != REG_ZERO) begin
                     result.expanded = fmt_i(uimm_lwsp, REG_SP, 3'd2, rd, OPC_LOAD);
                     result.legal    = 1'b1;
                  end
               end
               3'd3: begin
                  if (rd != REG_ZERO) begin
                     result.expanded = fmt_i(uimm_dsp, REG_SP, 3'd3, rd, OPC_LOAD);
                     result.legal    = 1'b1;
                  end
               end
               3'd4: begin
                  if (!cinsn[12]) begin
                     // c.mv, else c.jr
                     if (rs2 != REG_ZERO) begin
                        result.expanded = fmt_r(F7_BASE, rs2, REG_ZERO, 3'd0, rd, OPC_OP);
                        result.legal    = 1'b1;
                     end else if (rd != REG_ZERO) begin
                        result.expanded = fmt_i(12'd0, rd, 3'd0, REG_ZERO, OPC_JALR);
                        result.legal    = 1'b1;
                     end
                  end else begin
                     // c.add, c.ebreak, c.jalr
                     if (rs2 != REG_ZERO) begin
                        result.expanded = fmt_r(F7_BASE, rs2, rd, 3'd0, rd, OPC_OP);
                     end else if (rd == REG_ZERO) begin
                        result.expanded = fmt_i(IMM_EBREAK, REG_ZERO, 3'd0, REG_ZERO,
                                                OPC_SYSTEM);
                     end else begin
                        result.expanded = fmt_i(12'd0, rd, 3'd0, REG_RA, OPC_JALR);
                     end
                     result.legal = 1'b1;
                  end
               end
               3'd5: begin
                  result.expanded = fmt_s(uimm_dss, rs2, REG_SP, 3'd3, OPC_STORE_FP);
                  result.legal    = 1'b1;
               end
               3'd6: begin
                  result.expanded = fmt_s(uimm_swsp, rs2, REG_SP, 3'd2, OPC_STORE);
                  result.legal    = 1'b1;
               end
               default: begin
                  result.expanded = fmt_s(uimm_dss, rs2, REG_SP, 3'd3, OPC_STORE);
                  result.legal    = 1'b1;
               end
            endcase
         end
         default: begin
            result.legal = 1'b0;
         end
      endcase
   end

endmodule

// File: tb/rvc_instruction_expander_unit_test.sv
module rvc_instruction_expander_unit_test;
   import rvcx_pkg::*;

   localparam int RANDOM_ITEMS = 900;
   localparam int STALL_LIMIT  = 200;
   localparam int DRAIN_CYCLES = 10;
   localparam int MAX_REPORTS  = 100;

   // compressed funct3, quadrant 0
   localparam logic [2:0] C0_ADDI4SPN = 3'd0;
   localparam logic [2:0] C0_FLD      = 3'd1;
   localparam logic [2:0] C0_LW       = 3'd2;
   localparam logic [2:0] C0_LD       = 3'd3;
   localparam logic [2:0] C0_FSD      = 3'd5;
   localparam logic [2:0] C0_SW       = 3'd6;
   localparam logic [2:0] C0_SD       = 3'd7;
   // compressed funct3, quadrant 1
   localparam logic [2:0] C1_ADDI     = 3'd0;
   localparam logic [2:0] C1_ADDIW    = 3'd1;
   localparam logic [2:0] C1_LI       = 3'd2;
   localparam logic [2:0] C1_LUI      = 3'd3;
   localparam logic [2:0] C1_ALU      = 3'd4;
   localparam logic [2:0] C1_J        = 3'd5;
   localparam logic [2:0] C1_BEQZ     = 3'd6;
   localparam logic [2:0] C1_BNEZ     = 3'd7;
   // compressed funct3, quadrant 2
   localparam logic [2:0] C2_SLLI     = 3'd0;
   localparam logic [2:0] C2_FLDSP    = 3'd1;
   localparam logic [2:0] C2_LWSP     = 3'd2;
   localparam logic [2:0] C2_LDSP     = 3'd3;
   localparam logic [2:0] C2_JR_ADD   = 3'd4;
   localparam logic [2:0] C2_FSDSP    = 3'd5;
   localparam logic [2:0] C2_SWSP     = 3'd6;
   localparam logic [2:0] C2_SDSP     = 3'd7;
   localparam logic [1:0] QUAD_NONE   = 2'b11;

   // quadrant 1 alu group selectors
   localparam logic [1:0] ALU_SRLI = 2'd0;
   localparam logic [1:0] ALU_SRAI = 2'd1;
   localparam logic [1:0] ALU_ANDI = 2'd2;
   localparam logic [1:0] OP_SUB   = 2'd0;
   localparam logic [1:0] OP_XOR   = 2'd1;
   localparam logic [1:0] OP_OR    = 2'd2;
   localparam logic [1:0] OP_SUBW  = 2'd0;
   localparam logic [1:0] OP_ADDW  = 2'd1;

   // 32-bit funct3
   localparam logic [2:0] F3_ADD    = 3'd0;
   localparam logic [2:0] F3_JALR   = 3'd0;
   localparam logic [2:0] F3_PRIV   = 3'd0;
   localparam logic [2:0] F3_BEQ    = 3'd0;
   localparam logic [2:0] F3_BNE    = 3'd1;
   localparam logic [2:0] F3_SLL    = 3'd1;
   localparam logic [2:0] F3_WORD   = 3'd2;
   localparam logic [2:0] F3_DOUBLE = 3'd3;
   localparam logic [2:0] F3_XOR    = 3'd4;
   localparam logic [2:0] F3_SR     = 3'd5;
   localparam logic [2:0] F3_OR     = 3'd6;
   localparam logic [2:0] F3_AND    = 3'd7;

   typedef struct {
      cinsn_type cinsn;
      rsp_type   want;
   } pending_expansion_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rvcx_req_if req_ch ();
   rvcx_rsp_if rsp_ch ();

   rvc_instruction_expander_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   pending_expansion_type pending_expansions[$];
   pending_expansion_type oldest;
   int error_count = 0;
   int idle_cycles = 0;
   int req_quiet = 0;
   int rsp_quiet = 0;

   always #4 clock = ~clock;

   function automatic insn_type enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                      logic [4:0] rd, logic [6:0] op);
      return {imm, rs1, f3, rd, op};
   endfunction

   function automatic insn_type enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                      logic [2:0] f3, logic [6:0] op);
      return {imm[11:5], rs2, rs1, f3, imm[4:0], op};
   endfunction

   function automatic insn_type enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                      logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
      return {f7, rs2, rs1, f3, rd, op};
   endfunction

   function automatic insn_type enc_b(logic [12:0] imm, logic [4:0] rs1, logic [2:0] f3);
      return {imm[12], imm[10:5], REG_ZERO, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
   endfunction

   function automatic insn_type enc_j(logic [20:0] imm);
      return {imm[20], imm[10:1], imm[11], imm[19:12], REG_ZERO, OPC_JAL};
   endfunction

   function automatic rsp_type expand_cinsn(cinsn_type c);
      rsp_type     r;
      logic [4:0]  rd, rs2, prime_hi, prime_lo;
      logic [11:0] simm6;
      logic [11:0] shamt;
      logic [11:0] off_d, off_wsp, off_wss;
      logic [11:0] off_w;
      logic [11:0] off_dsp, off_dss;
      logic [11:0] nzu;
      logic [9:0]  nzs;
      logic [12:0] boff;
      logic [20:0] joff;
      logic [2:0]  alu_f3;
      r.legal    = 1'b1;
      r.expanded = '0;
      rd       = c[11:7];
      rs2      = c[6:2];
      prime_hi = {2'b01, c[9:7]};
      prime_lo = {2'b01, c[4:2]};
      simm6    = {{6{c[12]}}, c[12], c[6:2]};
      shamt    = {6'd0, c[12], c[6:2]};
      off_d    = {4'd0, c[6:5], c[12:10], 3'b000};
      off_w    = {5'd0, c[5], c[12:10], c[6], 2'b00};
      off_dsp  = {3'd0, c[4:2], c[12], c[6:5], 3'b000};
      off_wsp  = {4'd0, c[3:2], c[12], c[6:4], 2'b00};
      off_dss  = {3'd0, c[9:7], c[12:10], 3'b000};
      off_wss  = {4'd0, c[8:7], c[12:9], 2'b00};
      nzu      = {2'd0, c[10:7], c[12:11], c[5], c[6], 2'b00};
      nzs      = {c[12], c[4:3], c[5], c[2], c[6], 4'b0000};
      boff     = {{4{c[12]}}, c[12], c[6:5], c[2], c[11:10], c[4:3], 1'b0};
      joff     = {{9{c[12]}}, c[12], c[8], c[10:9], c[6], c[7], c[2], c[11], c[5:3], 1'b0};
      case (c[6:5])
         OP_SUB:  alu_f3 = F3_ADD;
         OP_XOR:  alu_f3 = F3_XOR;
         OP_OR:   alu_f3 = F3_OR;
         default: alu_f3 = F3_AND;
      endcase

      case (c[1:0])
         QUAD_0: begin
            case (c[15:13])
               C0_ADDI4SPN: begin
                  if (nzu == '0) r.legal = 1'b0;
                  else r.expanded = enc_i(nzu, REG_SP, F3_ADD, prime_lo, OPC_OP_IMM);
               end
               C0_FLD: r.expanded = enc_i(off_d, prime_hi, F3_DOUBLE, prime_lo, OPC_LOAD_FP);
               C0_LW:  r.expanded = enc_i(off_w, prime_hi, F3_WORD, prime_lo, OPC_LOAD);
               C0_LD:  r.expanded = enc_i(off_d, prime_hi, F3_DOUBLE, prime_lo, OPC_LOAD);
               C0_FSD: r.expanded = enc_s(off_d, prime_lo, prime_hi, F3_DOUBLE, OPC_STORE_FP);
               C0_SW:  r.expanded = enc_s(off_w, prime_lo, prime_hi, F3_WORD, OPC_STORE);
               C0_SD:  r.expanded = enc_s(off_d, prime_lo, prime_hi, F3_DOUBLE, OPC_STORE);
               default: r.legal = 1'b0;
            endcase
         end
         QUAD_1: begin
            case (c[15:13])
               C1_ADDI: r.expanded = enc_i(simm6, rd, F3_ADD, rd, OPC_OP_IMM);
               C1_ADDIW: begin
                  if (rd == REG_ZERO) r.legal = 1'b0;
                  else r.expanded = enc_i(simm6, rd, F3_ADD, rd, OPC_OP_IMM_32);
               end
               C1_LI: r.expanded = enc_i(simm6, REG_ZERO, F3_ADD, rd, OPC_OP_IMM);
               C1_LUI: begin
                  if (rd == REG_SP) begin
                     if (nzs == '0) r.legal = 1'b0;
                     else r.expanded = enc_i({{2{c[12]}}, nzs}, REG_SP, F3_ADD, REG_SP,
                                             OPC_OP_IMM);
                  end else if (rd == REG_ZERO || simm6 == '0) begin
                     r.legal = 1'b0;
                  end else begin
                     r.expanded = {{14{c[12]}}, c[12], c[6:2], rd, OPC_LUI};
                  end
               end
               C1_ALU: begin
                  case (c[11:10])
                     ALU_SRLI: r.expanded = enc_i(shamt, prime_hi, F3_SR, prime_hi, OPC_OP_IMM);
                     ALU_SRAI: r.expanded = enc_i(IMM_SRAI | shamt, prime_hi, F3_SR, prime_hi,
                                                  OPC_OP_IMM);
                     ALU_ANDI: r.expanded = enc_i(simm6, prime_hi, F3_AND, prime_hi, OPC_OP_IMM);
                     default: begin
                        if (!c[12]) begin
                           r.expanded = enc_r(c[6:5] == OP_SUB ? F7_SUB : F7_BASE, prime_lo,
                                              prime_hi, alu_f3, prime_hi, OPC_OP);
                        end else if (c[6:5] != OP_SUBW && c[6:5] != OP_ADDW) begin
                           r.legal = 1'b0;
                        end else begin
                           r.expanded = enc_r(c[6:5] == OP_SUBW ? F7_SUB : F7_BASE, prime_lo,
                                              prime_hi, F3_ADD, prime_hi, OPC_OP_32);
                        end
                     end
                  endcase
               end
               C1_J:    r.expanded = enc_j(joff);
               C1_BEQZ: r.expanded = enc_b(boff, prime_hi, F3_BEQ);
               default: r.expanded = enc_b(boff, prime_hi, F3_BNE);
            endcase
         end
         QUAD_2: begin
            case (c[15:13])
               C2_SLLI: begin
                  if (rd == REG_ZERO) r.legal = 1'b0;
                  else r.expanded = enc_i(shamt, rd, F3_SLL, rd, OPC_OP_IMM);
               end
               C2_FLDSP: r.expanded = enc_i(off_dsp, REG_SP, F3_DOUBLE, rd, OPC_LOAD_FP);
               C2_LWSP: begin
                  if (rd == REG_ZERO) r.legal = 1'b0;
                  else r.expanded = enc_i(off_wsp, REG_SP, F3_WORD, rd, OPC_LOAD);
               end
               C2_LDSP: begin
                  if (rd == REG_ZERO) r.legal = 1'b0;
                  else r.expanded = enc_i(off_dsp, REG_SP, F3_DOUBLE, rd, OPC_LOAD);
               end
               C2_JR_ADD: begin
                  if (!c[12]) begin
                     if (rs2 != REG_ZERO)
                        r.expanded = enc_r(F7_BASE, rs2, REG_ZERO, F3_ADD, rd, OPC_OP);
                     else if (rd == REG_ZERO) r.legal = 1'b0;
                     else r.expanded = enc_i('0, rd, F3_JALR, REG_ZERO, OPC_JALR);
                  end else begin
                     if (rs2 != REG_ZERO)
                        r.expanded = enc_r(F7_BASE, rs2, rd, F3_ADD, rd, OPC_OP);
                     else if (rd == REG_ZERO)
                        r.expanded = enc_i(IMM_EBREAK, REG_ZERO, F3_PRIV, REG_ZERO, OPC_SYSTEM);
                     else r.expanded = enc_i('0, rd, F3_JALR, REG_RA, OPC_JALR);
                  end
               end
               C2_FSDSP: r.expanded = enc_s(off_dss, rs2, REG_SP, F3_DOUBLE, OPC_STORE_FP);
               C2_SWSP:  r.expanded = enc_s(off_wss, rs2, REG_SP, F3_WORD, OPC_STORE);
               default:  r.expanded = enc_s(off_dss, rs2, REG_SP, F3_DOUBLE, OPC_STORE);
            endcase
         end
         default: r.legal = 1'b0;
      endcase
      if (!r.legal) r.expanded = '0;
      return r;
   endfunction

   // wait length for one side, with occasional runs of back-to-back traffic
   function automatic int draw_wait(ref int quiet);
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         quiet = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 10);
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
      error_count++;
   endtask

   task automatic issue_request(input cinsn_type c);
      int gap;
      pending_expansion_type entry;
      gap = draw_wait(req_quiet);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cinsn <= c;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      entry.cinsn = c;
      entry.want  = expand_cinsn(c);
      pending_expansions.push_back(entry);
   endtask

   function automatic cinsn_type random_cinsn();
      cinsn_type c;
      c = cinsn_type'($urandom);
      if ($urandom_range(0, 9) == 0) c[1:0] = QUAD_NONE;
      else c[1:0] = 2'($urandom_range(0, 2));
      // bias toward the register and immediate values that change decoding
      case ($urandom_range(0, 9))
         0: c[11:7] = REG_ZERO;
         1: c[6:2] = REG_ZERO;
         2: c[11:7] = REG_SP;
         3: c[12:2] = '0;
         4: begin
            c[12]  = 1'b0;
            c[6:2] = REG_ZERO;
         end
         default: ;
      endcase
      return c;
   endfunction

   task automatic test_special_cases();
      cinsn_type words[$] = '{
         16'hFFFF, 16'h0003,
         // reserved encodings
         16'h0000, 16'h001C, 16'h8000, 16'h2005, 16'h6101, 16'h6081, 16'h6005,
         16'h9C41, 16'h9C61, 16'h4002, 16'h6002, 16'h8002,
         // slli with rd zero is rejected
         16'h0006,
         // hints that expand literally
         16'h0001, 16'h507D, 16'h8006, 16'h9006, 16'h8001, 16'h8401, 16'h0082,
         // lui with negative immediate, ebreak, jalr, jr
         16'h70FD, 16'h9002, 16'h9082, 16'h8082
      };
      foreach (words[i]) issue_request(words[i]);
   endtask

   task automatic test_field_extremes();
      cinsn_type c;
      for (int f = 0; f < 8; f++) begin
         for (int q = 0; q < 3; q++) begin
            c = {3'(f), 11'h7FF, 2'(q)};
            issue_request(c);
         end
      end
   endtask

   task automatic test_random_stream();
      repeat (RANDOM_ITEMS) issue_request(random_cinsn());
   endtask

   initial begin
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      forever begin
         int stall;
         stall = draw_wait(rsp_quiet);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_expansions.size() == 0) begin
            report_mismatch($sformatf("result %h legal %b with no request pending",
                                      rsp_ch.expanded, rsp_ch.legal));
         end else begin
            oldest = pending_expansions.pop_front();
            if (rsp_ch.expanded !== oldest.want.expanded)
               report_mismatch($sformatf("cinsn %h: expanded %h, want %h", oldest.cinsn,
                                         rsp_ch.expanded, oldest.want.expanded));
            if (rsp_ch.legal !== oldest.want.legal)
               report_mismatch($sformatf("cinsn %h: legal %b, want %b", oldest.cinsn,
                                         rsp_ch.legal, oldest.want.legal));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("[rvc_instruction_expander_unit] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.cinsn = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_special_cases();
      test_field_extremes();
      test_random_stream();
      req_ch.valid <= 1'b0;
      while (pending_expansions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[rvc_instruction_expander_unit] OK");
      end else begin
         $display("[rvc_instruction_expander_unit] ERROR");
      end
      $finish;
   end

endmodule
